>>> design/epd_pkg.sv
// Package for the escaped packet deframer: event codes, register map,
// configuration bundle and result record. No dependencies.
package epd_pkg;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // register indexes, byte address = 4 * index
  localparam logic [2:0] RegBegin    = 3'd0;
  localparam logic [2:0] RegEnd      = 3'd1;
  localparam logic [2:0] RegEscape   = 3'd2;
  localparam logic [2:0] RegNoArg    = 3'd3;
  localparam logic [2:0] RegBufLen   = 3'd4;
  localparam logic [2:0] RegNotify   = 3'd5;

  localparam logic [7:0] BeginReset  = 8'd2;
  localparam logic [7:0] EndReset    = 8'd3;
  localparam logic [7:0] EscapeReset = 8'd27;
  localparam logic [7:0] NoArgReset  = 8'd255;
  localparam logic [8:0] BufLenReset = 9'd256;

  localparam logic [8:0] CountCmd = 9'd0;
  localparam logic [8:0] CountArg = 9'd1;
  localparam logic [8:0] CountPay = 9'd2;

  typedef enum logic [2:0] {
    EvEscape  = 3'd0,
    EvBegin   = 3'd1,
    EvStored  = 3'd2,
    EvEnd     = 3'd3,
    EvCleared = 3'd4,
    EvDropped = 3'd5
  } event_e;

  typedef enum logic {
    FuncRecv  = 1'b0,
    FuncClear = 1'b1
  } func_e;

  typedef struct packed {
    logic [7:0] begin_byte;
    logic [7:0] end_byte;
    logic [7:0] escape_byte;
    logic [7:0] no_arg_value;
    logic [8:0] buffer_length;
    logic       notify_mode;
  } cfg_t;

  typedef struct packed {
    event_e     event_res;
    logic [7:0] stored_byte;
    logic [7:0] stored_index;
    logic [7:0] command;
    logic [7:0] argument;
    logic [7:0] payload_count;
    logic       packet_ready;
    logic       overflow;
    logic       block_end;
  } result_t;

endpackage

>>> design/epd_if.sv
// Valid/ready channel interfaces for the deframer: received byte requests
// and result records. Depends on nothing.
interface epd_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] byte_in;
  logic       last_of_block;

  modport source (output valid, func, byte_in, last_of_block, input ready);
  modport sink   (input valid, func, byte_in, last_of_block, output ready);
endinterface

interface epd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] stored_byte;
  logic [7:0] stored_index;
  logic [7:0] command;
  logic [7:0] argument;
  logic [7:0] payload_count;
  logic       packet_ready;
  logic       overflow;
  logic       block_end;

  modport source (output valid, event_res, stored_byte, stored_index, command, argument,
                  payload_count, packet_ready, overflow, block_end, input ready);
  modport sink   (input valid, event_res, stored_byte, stored_index, command, argument,
                  payload_count, packet_ready, overflow, block_end, output ready);
endinterface

>>> design/epd_regs.sv
// APB configuration registers of the deframer (markers, argument default, limit, mode).
// Depends on epd_pkg.
module epd_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [epd_pkg::AddrW-1:0] paddr,
  input  logic [epd_pkg::DataW-1:0] pwdata,
  output logic [epd_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output epd_pkg::cfg_t             cfg_o
);

  epd_pkg::cfg_t cfg_q;
  logic          wr_en;
  logic [2:0]    idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.begin_byte    <= epd_pkg::BeginReset;
      cfg_q.end_byte      <= epd_pkg::EndReset;
      cfg_q.escape_byte   <= epd_pkg::EscapeReset;
      cfg_q.no_arg_value  <= epd_pkg::NoArgReset;
      cfg_q.buffer_length <= epd_pkg::BufLenReset;
      cfg_q.notify_mode   <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        epd_pkg::RegBegin:  cfg_q.begin_byte    <= pwdata[7:0];
        epd_pkg::RegEnd:    cfg_q.end_byte      <= pwdata[7:0];
        epd_pkg::RegEscape: cfg_q.escape_byte   <= pwdata[7:0];
        epd_pkg::RegNoArg:  cfg_q.no_arg_value  <= pwdata[7:0];
        epd_pkg::RegBufLen: cfg_q.buffer_length <= pwdata[8:0];
        epd_pkg::RegNotify: cfg_q.notify_mode   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      epd_pkg::RegBegin:  prdata = {24'd0, cfg_q.begin_byte};
      epd_pkg::RegEnd:    prdata = {24'd0, cfg_q.end_byte};
      epd_pkg::RegEscape: prdata = {24'd0, cfg_q.escape_byte};
      epd_pkg::RegNoArg:  prdata = {24'd0, cfg_q.no_arg_value};
      epd_pkg::RegBufLen: prdata = {23'd0, cfg_q.buffer_length};
      epd_pkg::RegNotify: prdata = {31'd0, cfg_q.notify_mode};
      default:            prdata = '0;
    endcase
  end

endmodule

>>> design/escaped_packet_deframer.sv
// Escaped packet deframer top level: byte decode, packet state and a
// two-entry result buffer. Depends on epd_pkg, epd_if and epd_regs.
//
// Usage: rx_i carries one request per accepted cycle: func 0 delivers a
// received byte, func 1 clears the packet ready flag. res_o returns exactly
// one result per request: the decode event, the stored byte and its index,
// and the packet command, argument, payload count, ready and overflow flags
// as they stand after that request, plus the echoed block_end marker.
// Each result is registered; one request is taken every cycle while rx_i
// is ready, set by the single decode stage that updates the packet state.
// A result register backed by a skid entry keeps rx_i ready for one more
// request while a result waits; rx_i ready drops only while both hold
// results, and nothing is lost or repeated however res_o stalls.
// Markers, argument default, buffer length and notify mode sit in the APB
// registers; the user must write them only while the block is idle, which
// the block itself does not enforce. Reset clears the packet state and
// empties the result buffer; the registers return to their defaults (begin
// 2, end 3, escape 27, no argument 255, length 256, notify off).
module escaped_packet_deframer #(
  parameter int unsigned BUF_DEPTH = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  epd_in_if.sink                    rx_i,
  epd_out_if.source                 res_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [epd_pkg::AddrW-1:0] paddr,
  input  logic [epd_pkg::DataW-1:0] pwdata,
  output logic [epd_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  localparam logic [8:0] DepthCap = 9'((BUF_DEPTH < 256) ? BUF_DEPTH : 256);

  epd_pkg::cfg_t    cfg;
  epd_pkg::result_t res_d, head_q, skid_q;
  logic             head_valid_q, skid_valid_q;
  logic             push, pop;

  logic       esc_q, esc_d;
  logic [8:0] count_q, count_d;
  logic [7:0] cmd_q, cmd_d, arg_q, arg_d, pay_q, pay_d;
  logic       rdy_q, rdy_d, ovf_q, ovf_d;
  logic [8:0] limit;
  logic       is_esc, is_begin, is_end;

  epd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign rx_i.ready = ~skid_valid_q;
  assign push       = rx_i.valid & rx_i.ready;
  assign pop        = res_o.valid & res_o.ready;

  assign limit    = (cfg.buffer_length < DepthCap) ? cfg.buffer_length : DepthCap;
  assign is_esc   = (rx_i.byte_in == cfg.escape_byte) & ~esc_q;
  assign is_begin = (rx_i.byte_in == cfg.begin_byte) & ~esc_q;
  assign is_end   = (rx_i.byte_in == cfg.end_byte) & ~esc_q;

  always_comb begin
    esc_d   = esc_q;
    count_d = count_q;
    cmd_d   = cmd_q;
    arg_d   = arg_q;
    pay_d   = pay_q;
    rdy_d   = rdy_q;
    ovf_d   = ovf_q;
    res_d.event_res    = epd_pkg::EvCleared;
    res_d.stored_byte  = '0;
    res_d.stored_index = '0;
    if (rx_i.func == epd_pkg::FuncClear) begin
      rdy_d = 1'b0;
    end else if (is_esc) begin
      esc_d = 1'b1;
      res_d.event_res = epd_pkg::EvEscape;
    end else if (is_begin) begin
      arg_d   = cfg.no_arg_value;
      pay_d   = '0;
      count_d = '0;
      rdy_d   = 1'b0;
      res_d.event_res = epd_pkg::EvBegin;
    end else if (is_end) begin
      if (!cfg.notify_mode) begin
        rdy_d = 1'b1;
      end
      res_d.event_res = epd_pkg::EvEnd;
    end else begin
      esc_d = 1'b0;
      if (count_q >= limit) begin
        ovf_d = 1'b1;
        res_d.event_res = epd_pkg::EvDropped;
      end else begin
        if (count_q == epd_pkg::CountCmd) begin
          cmd_d = rx_i.byte_in;
        end else if (count_q == epd_pkg::CountArg) begin
          arg_d = rx_i.byte_in;
        end else if (count_q == epd_pkg::CountPay) begin
          pay_d = 8'd1;
        end else begin
          pay_d = pay_q + 8'd1;
        end
        count_d = count_q + 9'd1;
        res_d.event_res    = epd_pkg::EvStored;
        res_d.stored_byte  = rx_i.byte_in;
        res_d.stored_index = count_q[7:0];
      end
    end
    res_d.command       = cmd_d;
    res_d.argument      = arg_d;
    res_d.payload_count = pay_d;
    res_d.packet_ready  = rdy_d;
    res_d.overflow      = ovf_d;
    res_d.block_end     = rx_i.last_of_block;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q   <= 1'b0;
      count_q <= '0;
      cmd_q   <= '0;
      arg_q   <= epd_pkg::NoArgReset;
      pay_q   <= '0;
      rdy_q   <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (push) begin
      esc_q   <= esc_d;
      count_q <= count_d;
      cmd_q   <= cmd_d;
      arg_q   <= arg_d;
      pay_q   <= pay_d;
      rdy_q   <= rdy_d;
      ovf_q   <= ovf_d;
    end
  end

  // result buffer: head drives the port, skid catches a request during a stall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!head_valid_q || pop) begin
      head_valid_q <= skid_valid_q | push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!head_valid_q || pop) begin
      if (skid_valid_q) begin
        head_q <= skid_q;
      end else if (push) begin
        head_q <= res_d;
      end
    end else if (push) begin
      skid_q <= res_d;
    end
  end

  assign res_o.valid         = head_valid_q;
  assign res_o.event_res     = head_q.event_res;
  assign res_o.stored_byte   = head_q.stored_byte;
  assign res_o.stored_index  = head_q.stored_index;
  assign res_o.command       = head_q.command;
  assign res_o.argument      = head_q.argument;
  assign res_o.payload_count = head_q.payload_count;
  assign res_o.packet_ready  = head_q.packet_ready;
  assign res_o.overflow      = head_q.overflow;
  assign res_o.block_end     = head_q.block_end;

  a_skid_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> head_valid_q)
    else $error("skid entry held without a head result");

  a_overflow_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("overflow flag cleared before reset");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCap)
    else $error("byte count beyond buffer depth");

  a_store_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && res_d.event_res == epd_pkg::EvStored) |=> count_q == $past(count_q) + 9'd1)
    else $error("stored byte did not advance the count");

endmodule
